[hdl/fpss_pkg.sv]
// shared types and codes for the front panel switch scanner
package fpss_pkg;

    localparam int unsigned DEBOUNCE_W     = 24;
    localparam int unsigned TIME_W         = 32;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(50 * 1000);

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TAKE   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_STOP         = 3'd1,
        CMD_RUN          = 3'd2,
        CMD_STEP         = 3'd3,
        CMD_EXAMINE      = 3'd4,
        CMD_EXAMINE_NEXT = 3'd5,
        CMD_DEPOSIT      = 3'd6,
        CMD_DEPOSIT_NEXT = 3'd7
    } cmd_t;

    typedef struct packed {
        op_t               op;
        logic              transfer_ok;
        logic              cpu_halted;
        logic [TIME_W-1:0] now_us;
        logic [7:0]        status_lamps;
        logic [7:0]        data_lamps;
        logic [15:0]       address_lamps;
        logic [7:0]        cmd_raw;
        logic [7:0]        switch_raw_low;
        logic [7:0]        switch_raw_high;
    } sample_t;

    typedef struct packed {
        logic        lamp_latch;
        logic [31:0] panel_frame;
        logic        bus_switch_write;
        logic [15:0] bus_switch_value;
        cmd_t        taken_command;
    } result_t;

endpackage

[hdl/fpss_core.sv]
// debounce state, command slot, lamp memory and per-word result logic
module fpss_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  fpss_pkg::sample_t                 item,
    input  logic [fpss_pkg::DEBOUNCE_W-1:0]   debounce_time_us,
    output fpss_pkg::result_t                 res
);
    import fpss_pkg::*;

    // command switch bits
    localparam logic [7:0] BIT_RUN          = 8'h01;
    localparam logic [7:0] BIT_STOP         = 8'h02;
    localparam logic [7:0] BIT_STEP         = 8'h08;
    localparam logic [7:0] BIT_EXAMINE_NEXT = 8'h10;
    localparam logic [7:0] BIT_EXAMINE      = 8'h20;
    localparam logic [7:0] BIT_DEPOSIT_NEXT = 8'h40;
    localparam logic [7:0] BIT_DEPOSIT      = 8'h80;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic cmd_t pick_command(input logic [7:0] bits, input logic stopped);
        cmd_t c;
        if ((bits & BIT_STOP) != '0)
            c = CMD_STOP;
        else if (!stopped)
            c = CMD_NONE;
        else if ((bits & BIT_RUN) != '0)
            c = CMD_RUN;
        else if ((bits & BIT_STEP) != '0)
            c = CMD_STEP;
        else if ((bits & BIT_EXAMINE) != '0)
            c = CMD_EXAMINE;
        else if ((bits & BIT_EXAMINE_NEXT) != '0)
            c = CMD_EXAMINE_NEXT;
        else if ((bits & BIT_DEPOSIT) != '0)
            c = CMD_DEPOSIT;
        else if ((bits & BIT_DEPOSIT_NEXT) != '0)
            c = CMD_DEPOSIT_NEXT;
        else
            c = CMD_NONE;
        return c;
    endfunction

    logic [7:0]        last_cmd_reg, last_cmd_next;
    logic [7:0]        stable_cmd_reg, stable_cmd_next;
    logic [TIME_W-1:0] cmd_time_reg, cmd_time_next;
    logic [15:0]       last_sw_reg, last_sw_next;
    logic [15:0]       stable_sw_reg, stable_sw_next;
    logic [TIME_W-1:0] sw_time_reg, sw_time_next;
    cmd_t              pending_reg, pending_next;
    logic [7:0]        shown_status_reg, shown_status_next;
    logic [7:0]        shown_data_reg, shown_data_next;
    logic [15:0]       shown_address_reg, shown_address_next;

    logic              latch;
    logic [15:0]       sw;
    logic [TIME_W-1:0] cmd_age;
    logic [TIME_W-1:0] sw_age;
    logic [TIME_W-1:0] limit;
    cmd_t              picked;

    assign latch   = (item.status_lamps != shown_status_reg)
                  || (item.data_lamps != shown_data_reg)
                  || (item.address_lamps != shown_address_reg);
    assign sw      = ~{flip8(item.switch_raw_high), flip8(item.switch_raw_low)};
    assign cmd_age = item.now_us - cmd_time_reg;
    assign sw_age  = item.now_us - sw_time_reg;
    assign limit   = {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time_us};
    assign picked  = pick_command(item.cmd_raw, item.cpu_halted);

    always_comb
    begin
        last_cmd_next      = last_cmd_reg;
        stable_cmd_next    = stable_cmd_reg;
        cmd_time_next      = cmd_time_reg;
        last_sw_next       = last_sw_reg;
        stable_sw_next     = stable_sw_reg;
        sw_time_next       = sw_time_reg;
        pending_next       = pending_reg;
        shown_status_next  = shown_status_reg;
        shown_data_next    = shown_data_reg;
        shown_address_next = shown_address_reg;
        res                = '0;
        res.taken_command  = CMD_NONE;

        if (item.op == OP_TAKE)
        begin
            res.taken_command = pending_reg;
            pending_next      = CMD_NONE;
        end
        else
        begin
            res.lamp_latch  = latch;
            res.panel_frame = {flip8(item.address_lamps[7:0]),
                               flip8(item.address_lamps[15:8]),
                               flip8(item.data_lamps),
                               flip8(item.status_lamps)};
            if (item.transfer_ok)
            begin
                if (item.cmd_raw != last_cmd_reg)
                begin
                    last_cmd_next = item.cmd_raw;
                    cmd_time_next = item.now_us;
                end
                else if (item.cmd_raw != stable_cmd_reg && cmd_age >= limit)
                begin
                    stable_cmd_next = item.cmd_raw;
                    if (picked != CMD_NONE && pending_reg == CMD_NONE)
                    begin
                        if (item.cpu_halted && (picked == CMD_EXAMINE
                            || picked == CMD_DEPOSIT || picked == CMD_DEPOSIT_NEXT))
                        begin
                            res.bus_switch_write = 1'b1;
                            res.bus_switch_value = stable_sw_reg;
                        end
                        pending_next = picked;
                    end
                end

                if (sw != last_sw_reg)
                begin
                    last_sw_next = sw;
                    sw_time_next = item.now_us;
                end
                else if (sw != stable_sw_reg && sw_age >= limit)
                begin
                    stable_sw_next = sw;
                    if (item.cpu_halted)
                    begin
                        res.bus_switch_write = 1'b1;
                        res.bus_switch_value = sw;
                    end
                end

                if (latch)
                begin
                    shown_status_next  = item.status_lamps;
                    shown_data_next    = item.data_lamps;
                    shown_address_next = item.address_lamps;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cmd_reg      <= '0;
            stable_cmd_reg    <= '0;
            cmd_time_reg      <= '0;
            last_sw_reg       <= '0;
            stable_sw_reg     <= '0;
            sw_time_reg       <= '0;
            pending_reg       <= CMD_NONE;
            shown_status_reg  <= '0;
            shown_data_reg    <= '0;
            shown_address_reg <= '0;
        end
        else if (fire)
        begin
            last_cmd_reg      <= last_cmd_next;
            stable_cmd_reg    <= stable_cmd_next;
            cmd_time_reg      <= cmd_time_next;
            last_sw_reg       <= last_sw_next;
            stable_sw_reg     <= stable_sw_next;
            sw_time_reg       <= sw_time_next;
            pending_reg       <= pending_next;
            shown_status_reg  <= shown_status_next;
            shown_data_reg    <= shown_data_next;
            shown_address_reg <= shown_address_next;
        end
    end

    a_take_empties_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_TAKE |=> pending_reg == CMD_NONE)
        else $error("command slot not emptied by take");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pending_reg) && $stable(stable_cmd_reg) && $stable(stable_sw_reg))
        else $error("state changed without a word");

    a_failed_transfer_keeps_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_SAMPLE && !item.transfer_ok
        |=> $stable(shown_address_reg) && $stable(last_sw_reg) && $stable(last_cmd_reg))
        else $error("failed transfer changed panel memory");

    a_slot_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == OP_SAMPLE && pending_reg != CMD_NONE
        |=> $stable(pending_reg))
        else $error("full command slot overwritten");

endmodule

[hdl/front_panel_switch_scanner.sv]
// Front panel switch scanner top level: input register, core, result register
//
// The sample channel (sample_valid / sample_stall) carries one word per panel
// exchange (op = sample) or a request to take the pending command (op = take).
// The result channel (result_valid / result_stall) returns exactly one word
// for every accepted word, in order: lamp frame, latch strobe, switch bus write
// and the taken command.
// A word that is accepted is captured in the input register, worked out by the
// core and loaded into the result register, where result_valid rises; while
// the receiver stalls it waits in the input register.
// Throughput is one word per cycle while result_stall is low; the input
// register takes a new word while the result register holds the previous one.
// When the receiver stalls, the result word holds and the input register
// holds its word; sample_stall rises only while both are full.
// debounce_write / debounce_data load the debounce time in microseconds; the
// user must write it only while no word is in flight; the block has no guard.
// Reset clears both valid flags, the debounce and lamp memory, the command
// slot, and sets the debounce time to 50000 us.
module front_panel_switch_scanner (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic                             op,
    input  logic                             transfer_ok,
    input  logic                             cpu_halted,
    input  logic [fpss_pkg::TIME_W-1:0]      now_us,
    input  logic [7:0]                       status_lamps,
    input  logic [7:0]                       data_lamps,
    input  logic [15:0]                      address_lamps,
    input  logic [7:0]                       cmd_raw,
    input  logic [7:0]                       switch_raw_low,
    input  logic [7:0]                       switch_raw_high,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             lamp_latch,
    output logic [31:0]                      panel_frame,
    output logic                             bus_switch_write,
    output logic [15:0]                      bus_switch_value,
    output logic [2:0]                       taken_command,
    input  logic                             debounce_write,
    input  logic [fpss_pkg::DEBOUNCE_W-1:0]  debounce_data
);
    import fpss_pkg::*;

    logic                  stage_valid_reg, stage_valid_next;
    sample_t               stage_reg;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic                  advance;
    logic                  fire;
    logic                  accept;
    result_t               core_res;

    assign advance      = !result_valid_reg || !result_stall;
    assign fire         = stage_valid_reg && advance;
    assign sample_stall = stage_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign stage_valid_next  = sample_stall ? 1'b1 : sample_valid;
    assign result_valid_next = advance ? stage_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            debounce_reg     <= DEBOUNCE_RESET;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (debounce_write)
                debounce_reg <= debounce_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.op              <= op_t'(op);
            stage_reg.transfer_ok     <= transfer_ok;
            stage_reg.cpu_halted      <= cpu_halted;
            stage_reg.now_us          <= now_us;
            stage_reg.status_lamps    <= status_lamps;
            stage_reg.data_lamps      <= data_lamps;
            stage_reg.address_lamps   <= address_lamps;
            stage_reg.cmd_raw         <= cmd_raw;
            stage_reg.switch_raw_low  <= switch_raw_low;
            stage_reg.switch_raw_high <= switch_raw_high;
        end
        if (fire)
            result_reg <= core_res;
    end

    fpss_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .item             (stage_reg),
        .debounce_time_us (debounce_reg),
        .res              (core_res)
    );

    assign result_valid     = result_valid_reg;
    assign lamp_latch       = result_reg.lamp_latch;
    assign panel_frame      = result_reg.panel_frame;
    assign bus_switch_write = result_reg.bus_switch_write;
    assign bus_switch_value = result_reg.bus_switch_value;
    assign taken_command    = result_reg.taken_command;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> stage_valid_reg && result_valid_reg)
        else $error("stall raised with room in the pipeline");

    a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid_reg)
        else $error("word lost between input and result register");

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance |=> stage_valid_reg && $stable(stage_reg))
        else $error("held input word changed");

endmodule
